// ===== rtl/core/mbbc_pkg.sv =====
package mbbc_pkg;

    // Stack geometry and counter widths
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int OFFSET_BITS = 16;
    localparam int DEPTH_BITS  = 17;
    localparam int OUT_OFF_BITS = 16;

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = '1;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_LIM  = DEPTH_BITS'(STACK_DEPTH);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    localparam logic [7:0] BACKSLASH_CODE = 8'd92;
    localparam logic [7:0] SPACE_CODE     = 8'd32;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_ANGLE  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_ANGLE = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_ROUND  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_ROUND = CFG_IDX_BITS'(3);

    localparam logic [7:0] RST_OPEN_ANGLE  = 8'd60;
    localparam logic [7:0] RST_CLOSE_ANGLE = 8'd62;
    localparam logic [7:0] RST_OPEN_ROUND  = 8'd40;
    localparam logic [7:0] RST_CLOSE_ROUND = 8'd41;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic                    mismatch_found;
        logic [OUT_OFF_BITS-1:0] mismatch_offset;
    } t_out_item;

    // Where the result of a terminator comes from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_EARLY,
        SRC_ANGLE,
        SRC_ROUND
    } t_src;

endpackage

// ===== rtl/core/markup_bracket_balance_checker.sv =====
// Bracket balance checker for two kinds of bracket (angle and round).
//
// Input channel: one item per accepted handshake (i_in_valid high, o_in_stall
// low). A text item carries one byte; an item with end_of_text set is the
// terminator and produces exactly one result item. Text items produce none.
// Output channel: o_out_valid / i_out_stall, result held while stalled.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..3 selects
// the open angle, close angle, open round and close round byte codes. Other
// indexes are ignored. Write config only while the block is idle.
//
// Throughput: one item per cycle while o_in_stall is low. Each stack is a
// 1R1W synchronous RAM; a text byte costs at most one RAM write, a terminator
// one read of each RAM. An accepted terminator's RAM reads and result source
// go into the read stage; the result select then loads the output register.
// Backpressure: a terminator waits in the read stage while the output
// register is stalled; during that time o_in_stall is high, until the output
// is taken.
// Reset: synchronous, active low; config returns to '<' '>' '(' ')', depths,
// position and error flag clear. Stack RAMs are not cleared and need no pass.
module markup_bracket_balance_checker
    import mbbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // text in
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    // result out
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    // config writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]              i_cfg_data
);

    // ---------------- config registers ----------------
    logic [7:0] r_open_angle, r_close_angle, r_open_round, r_close_round;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_angle  <= RST_OPEN_ANGLE;
            r_close_angle <= RST_CLOSE_ANGLE;
            r_open_round  <= RST_OPEN_ROUND;
            r_close_round <= RST_CLOSE_ROUND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OPEN_ANGLE:  r_open_angle  <= i_cfg_data;
                CFG_CLOSE_ANGLE: r_close_angle <= i_cfg_data;
                CFG_OPEN_ROUND:  r_open_round  <= i_cfg_data;
                CFG_CLOSE_ROUND: r_close_round <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- scan state ----------------
    logic [DEPTH_BITS-1:0]  r_angle_depth, n_angle_depth;
    logic [DEPTH_BITS-1:0]  r_round_depth, n_round_depth;
    logic [7:0]             r_prev, n_prev;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_err, n_err;
    logic [OFFSET_BITS-1:0] r_err_off, n_err_off;

    // read stage (terminator waiting for RAM data)
    logic                   r_s1_vld, n_s1_vld;
    t_src                   r_s1_src, n_s1_src;
    logic [OFFSET_BITS-1:0] r_s1_off, n_s1_off;

    // output register
    logic                   r_out_vld, n_out_vld;
    t_out_item              r_out, n_out;

    // RAM controls
    logic                   angle_we, round_we, rd_en;
    logic [STACK_AW-1:0]    angle_waddr, round_waddr, angle_raddr, round_raddr;
    logic [OFFSET_BITS-1:0] r_angle_q, r_round_q;

    logic in_acc, s1_move, is_term, escaped;
    logic angle_in_stack, round_in_stack;

    // s1 can advance when the output register is empty or being drained
    assign s1_move    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && r_out_vld && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_term    = i_in_data.end_of_text;
    assign escaped    = (r_prev == BACKSLASH_CODE);

    // stack top is readable when depth is in 1..STACK_DEPTH
    assign angle_in_stack = (r_angle_depth != '0) && (r_angle_depth <= DEPTH_LIM);
    assign round_in_stack = (r_round_depth != '0) && (r_round_depth <= DEPTH_LIM);

    assign angle_waddr = STACK_AW'(r_angle_depth);
    assign round_waddr = STACK_AW'(r_round_depth);
    assign angle_raddr = STACK_AW'(r_angle_depth - 1'b1);
    assign round_raddr = STACK_AW'(r_round_depth - 1'b1);
    assign rd_en       = in_acc && is_term;

    always_comb begin
        n_angle_depth = r_angle_depth;
        n_round_depth = r_round_depth;
        n_prev        = r_prev;
        n_pos         = r_pos;
        n_err         = r_err;
        n_err_off     = r_err_off;
        n_s1_vld      = r_s1_vld;
        n_s1_src      = r_s1_src;
        n_s1_off      = r_s1_off;
        n_out_vld     = r_out_vld;
        n_out         = r_out;
        angle_we      = 1'b0;
        round_we      = 1'b0;

        // output side
        if (s1_move) begin
            n_out_vld = 1'b1;
            n_out.mismatch_found = (r_s1_src != SRC_NONE);
            unique case (r_s1_src)
                SRC_EARLY: n_out.mismatch_offset = OUT_OFF_BITS'(r_s1_off);
                SRC_ANGLE: n_out.mismatch_offset = OUT_OFF_BITS'(r_angle_q);
                SRC_ROUND: n_out.mismatch_offset = OUT_OFF_BITS'(r_round_q);
                default:   n_out.mismatch_offset = '0;
            endcase
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (s1_move) begin
            n_s1_vld = 1'b0;
        end

        if (in_acc) begin
            if (is_term) begin
                n_s1_vld = 1'b1;
                n_s1_off = r_err_off;
                priority if (r_err) begin
                    n_s1_src = SRC_EARLY;
                end else if (angle_in_stack) begin
                    n_s1_src = SRC_ANGLE;
                end else if (round_in_stack) begin
                    n_s1_src = SRC_ROUND;
                end else begin
                    n_s1_src = SRC_NONE;
                end
                // back to the post-reset scan state
                n_angle_depth = '0;
                n_round_depth = '0;
                n_prev        = SPACE_CODE;
                n_pos         = '0;
                n_err         = 1'b0;
                n_err_off     = '0;
            end else begin
                if (!r_err) begin
                    // first matching code wins
                    priority if (i_in_data.text_byte == r_open_angle) begin
                        if (!escaped) begin
                            angle_we = (r_angle_depth < DEPTH_LIM);
                            if (r_angle_depth != DEPTH_MAX) begin
                                n_angle_depth = r_angle_depth + 1'b1;
                            end
                        end
                    end else if (i_in_data.text_byte == r_close_angle) begin
                        if (!escaped) begin
                            if (r_angle_depth == '0) begin
                                n_err     = 1'b1;
                                n_err_off = r_pos;
                            end else begin
                                n_angle_depth = r_angle_depth - 1'b1;
                            end
                        end
                    end else if (i_in_data.text_byte == r_open_round) begin
                        round_we = (r_round_depth < DEPTH_LIM);
                        if (r_round_depth != DEPTH_MAX) begin
                            n_round_depth = r_round_depth + 1'b1;
                        end
                    end else if (i_in_data.text_byte == r_close_round) begin
                        if (r_round_depth == '0) begin
                            n_err     = 1'b1;
                            n_err_off = r_pos;
                        end else begin
                            n_round_depth = r_round_depth - 1'b1;
                        end
                    end else begin
                        // ordinary byte, no stack change
                    end
                end
                n_prev = i_in_data.text_byte;
                if (r_pos != OFFSET_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_depth <= '0;
            r_round_depth <= '0;
            r_prev        <= SPACE_CODE;
            r_pos         <= '0;
            r_err         <= 1'b0;
            r_err_off     <= '0;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_angle_depth <= n_angle_depth;
            r_round_depth <= n_round_depth;
            r_prev        <= n_prev;
            r_pos         <= n_pos;
            r_err         <= n_err;
            r_err_off     <= n_err_off;
            r_s1_vld      <= n_s1_vld;
            r_out_vld     <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1_src <= n_s1_src;
        r_s1_off <= n_s1_off;
        r_out    <= n_out;
    end

    // ---------------- stack RAMs ----------------
    // Pushes write at accept; the terminator is a later item, so its read never
    // overlaps a write to the same entry of the same scan.
    logic [OFFSET_BITS-1:0] angle_mem [STACK_DEPTH];
    logic [OFFSET_BITS-1:0] round_mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (angle_we) begin
            angle_mem[angle_waddr] <= r_pos;
        end
        if (rd_en) begin
            r_angle_q <= angle_mem[angle_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (round_we) begin
            round_mem[round_waddr] <= r_pos;
        end
        if (rd_en) begin
            r_round_q <= round_mem[round_raddr];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_vld)
        else $error("read stage advanced but output register empty");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_term |=> r_s1_vld && !r_err && (r_pos == '0)
                              && (r_angle_depth == '0) && (r_round_depth == '0))
        else $error("terminator did not restart the scan");

    a_err_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(in_acc && is_term) |=> $stable(r_angle_depth)
                                          && $stable(r_round_depth) && $stable(r_err_off))
        else $error("stack state changed after an early error");

    a_clean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.mismatch_found |-> r_out.mismatch_offset == '0)
        else $error("balanced result with nonzero offset");

endmodule

// ===== tb/bracket_result_checker.sv =====
// Watches the three channels of the bracket checker, predicts each result
// item from the accepted text items and compares it with the block's output.
module bracket_result_checker
    import mbbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  t_in_item                i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  t_out_item               i_out_data,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_seen
);

    localparam int ANGLE = 0;
    localparam int ROUND = 1;

    logic [7:0]             code_open_angle;
    logic [7:0]             code_close_angle;
    logic [7:0]             code_open_round;
    logic [7:0]             code_close_round;

    // per-kind offset stacks and nesting depths
    logic [OFFSET_BITS-1:0] open_offsets [2][STACK_DEPTH];
    logic [DEPTH_BITS-1:0]  nest_depth [2];
    logic [7:0]             last_byte;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic                   stray_seen;
    logic [OFFSET_BITS-1:0] stray_pos;

    t_out_item              results_due [$];
    int                     fails = 0;
    int                     checked = 0;
    int                     due_count = 0;

    assign o_fail_count   = fails;
    assign o_pending      = due_count;
    assign o_results_seen = checked;

    task automatic restart_text();
        nest_depth[ANGLE] = '0;
        nest_depth[ROUND] = '0;
        last_byte  = SPACE_CODE;
        byte_pos   = '0;
        stray_seen = 1'b0;
        stray_pos  = '0;
    endtask

    task automatic open_bracket(input int kind);
        if (nest_depth[kind] < DEPTH_LIM) begin
            open_offsets[kind][nest_depth[kind][STACK_AW-1:0]] = byte_pos;
        end
        if (nest_depth[kind] != DEPTH_MAX) begin
            nest_depth[kind] = nest_depth[kind] + 1'b1;
        end
    endtask

    task automatic close_bracket(input int kind);
        if (nest_depth[kind] == '0) begin
            stray_seen = 1'b1;
            stray_pos  = byte_pos;
        end else begin
            nest_depth[kind] = nest_depth[kind] - 1'b1;
        end
    endtask

    // a kind nested past the stack has no stored offset and is skipped
    function automatic logic kind_reportable(input int kind);
        return nest_depth[kind] != '0 && nest_depth[kind] <= DEPTH_LIM;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] innermost_offset(input int kind);
        return open_offsets[kind][STACK_AW'(nest_depth[kind] - 1'b1)];
    endfunction

    task automatic predict_item(input t_in_item it);
        t_out_item want;
        logic      escaped;
        if (it.end_of_text) begin
            want = '0;
            if (stray_seen) begin
                want.mismatch_found  = 1'b1;
                want.mismatch_offset = OUT_OFF_BITS'(stray_pos);
            end else if (kind_reportable(ANGLE)) begin
                want.mismatch_found  = 1'b1;
                want.mismatch_offset = OUT_OFF_BITS'(innermost_offset(ANGLE));
            end else if (kind_reportable(ROUND)) begin
                want.mismatch_found  = 1'b1;
                want.mismatch_offset = OUT_OFF_BITS'(innermost_offset(ROUND));
            end
            results_due.push_back(want);
            restart_text();
        end else begin
            if (!stray_seen) begin
                escaped = (last_byte == BACKSLASH_CODE);
                // first matching code wins when codes overlap
                if (it.text_byte == code_open_angle) begin
                    if (!escaped) open_bracket(ANGLE);
                end else if (it.text_byte == code_close_angle) begin
                    if (!escaped) close_bracket(ANGLE);
                end else if (it.text_byte == code_open_round) begin
                    open_bracket(ROUND);
                end else if (it.text_byte == code_close_round) begin
                    close_bracket(ROUND);
                end
            end
            last_byte = it.text_byte;
            if (byte_pos != OFFSET_MAX) byte_pos = byte_pos + 1'b1;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            $error("unexpected result item: mismatch_found %0d mismatch_offset %0d",
                   got.mismatch_found, got.mismatch_offset);
            fails++;
        end else begin
            want = results_due.pop_front();
            checked++;
            if (got.mismatch_found !== want.mismatch_found) begin
                $error("mismatch_found: expected %0d, got %0d",
                       want.mismatch_found, got.mismatch_found);
                fails++;
            end
            if (got.mismatch_offset !== want.mismatch_offset) begin
                $error("mismatch_offset: expected %0d, got %0d",
                       want.mismatch_offset, got.mismatch_offset);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_open_angle  = RST_OPEN_ANGLE;
            code_close_angle = RST_CLOSE_ANGLE;
            code_open_round  = RST_OPEN_ROUND;
            code_close_round = RST_CLOSE_ROUND;
            restart_text();
            results_due.delete();
        end else begin
            // a result is registered after its terminator, so check before predicting
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OPEN_ANGLE:  code_open_angle  = i_cfg_data;
                    CFG_CLOSE_ANGLE: code_close_angle = i_cfg_data;
                    CFG_OPEN_ROUND:  code_open_round  = i_cfg_data;
                    CFG_CLOSE_ROUND: code_close_round = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_data);
        end
        due_count = results_due.size();
    end

endmodule

// ===== tb/tb_markup_bracket_balance_checker.sv =====
// Top of the bracket checker bench: clock, reset, stimulus and verdict.
// Prediction and comparison live in bracket_result_checker.
module tb_markup_bracket_balance_checker;
    import mbbc_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 6;
    localparam int QUIET_LIMIT     = 4000;  // cycles without any handshake
    localparam int BLOCKS          = 6;
    localparam int ITEMS_PER_BLOCK = 90;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = '1;
    localparam logic [7:0] FILLER_BYTE = 8'h78;   // 'x', never a bracket by default

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    t_in_item                in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [7:0]              cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;

    // bracket codes as currently programmed, used to shape the text
    logic [7:0] open_angle  = RST_OPEN_ANGLE;
    logic [7:0] close_angle = RST_CLOSE_ANGLE;
    logic [7:0] open_round  = RST_OPEN_ROUND;
    logic [7:0] close_round = RST_CLOSE_ROUND;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_bytes        = 0;
    int n_terms        = 0;
    int n_settings     = 1;
    int block_items    = 0;
    int quiet_cycles   = 0;

    markup_bracket_balance_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bracket_result_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: a run that stops handshaking is a hang.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[markup_bracket_balance_checker] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item and hold it until taken. Valid is left high after the
    // handshake so back-to-back items never see a low/high pair in one step.
    // Stall is read at the falling edge, where it is settled.
    task automatic send_item(input logic [7:0] b, input logic eot);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'{text_byte: b, end_of_text: eot};
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        if (eot) n_terms++;
        else n_bytes++;
        block_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    // terminator; its text byte is don't-care, so it is random
    task automatic end_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_run(input logic [7:0] b, input int count);
        for (int i = 0; i < count; i++) send_byte(b);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Wait until every terminator has its result, then let the pipe drain
    // (text items give no result but may still be in flight).
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic load_codes(input logic [7:0] oa, input logic [7:0] ca,
                              input logic [7:0] orn, input logic [7:0] crn);
        write_reg(CFG_OPEN_ANGLE, oa);
        write_reg(CFG_CLOSE_ANGLE, ca);
        write_reg(CFG_OPEN_ROUND, orn);
        write_reg(CFG_CLOSE_ROUND, crn);
        cfg_valid   <= 1'b0;
        open_angle  = oa;
        close_angle = ca;
        open_round  = orn;
        close_round = crn;
        n_settings++;
    endtask

    // One random text then its terminator. Most texts are tidy: closers match
    // the innermost opener and everything is closed at the end. The rest mix
    // in stray closers of either kind and leave brackets open.
    task automatic send_random_text();
        bit kinds [$];   // 1 = round, 0 = angle
        int len;
        int pick;
        bit tidy;
        bit k;
        len  = $urandom_range(0, 30);
        tidy = ($urandom_range(0, 99) < 75);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                k = 1'($urandom_range(0, 1));
                send_byte(k ? open_round : open_angle);
                kinds.push_back(k);
            end else if (pick < 55) begin
                if (tidy && kinds.size() == 0) begin
                    send_byte(FILLER_BYTE);
                end else begin
                    k = tidy ? kinds.pop_back() : 1'($urandom_range(0, 1));
                    send_byte(k ? close_round : close_angle);
                end
            end else if (pick < 63) begin
                // escaped angle bracket
                send_byte(BACKSLASH_CODE);
                send_byte($urandom_range(0, 1) ? open_angle : close_angle);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        if (tidy) begin
            while (kinds.size() != 0) send_byte(kinds.pop_back() ? close_round : close_angle);
        end
        end_text();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed texts, reset codes, no idling ----
        end_text();                  // empty text: balanced
        send_str("<a>");             // balanced
        end_text();
        send_str("(<");              // angle wins over round: offset 1
        end_text();
        send_run(open_round, 2);     // zero byte is ordinary text
        send_byte(8'h00);
        end_text();
        send_str("><)");             // stray closer at 0, later bytes ignored
        end_text();
        send_str("\\<\\>(");         // both angles escaped, round open at 4
        end_text();
        send_str("()\\)");           // backslash does not escape round: stray at 3
        end_text();

        // ---- nesting past the stack ----
        send_run(open_round, 3);     // angle too deep, falls through to round at 2
        send_run(open_angle, STACK_DEPTH + 1);
        end_text();
        send_run(open_angle, STACK_DEPTH + 2);   // back to a full stack: offset 255
        send_run(close_angle, 2);
        end_text();
        send_run(open_round, STACK_DEPTH + 1);   // only kind too deep: balanced
        end_text();
        send_run(open_round, STACK_DEPTH);       // exactly full: offset 255
        end_text();

        // ---- random texts, several code settings and idling modes ----
        for (int blk = 0; blk < BLOCKS; blk++) begin
            if (blk > 0) settle();
            case (blk)
                1: begin
                    write_reg(CFG_IDX_UNUSED, 8'h3C);   // must be ignored
                    load_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
                end
                2: load_codes(BACKSLASH_CODE, 8'h00, 8'h5B, 8'h5D);
                3: load_codes(8'hAA, 8'hAA, 8'hAA, 8'hAA);
                4: load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                5: load_codes(RST_OPEN_ANGLE, RST_CLOSE_ANGLE, RST_OPEN_ROUND, RST_CLOSE_ROUND);
                default: ;
            endcase
            if (blk < 2) begin
                send_idle_pct  = 6;
                recv_stall_pct = 50;
            end else if (blk < 4) begin
                send_idle_pct  = 50;
                recv_stall_pct = 6;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            block_items = 0;
            while (block_items < ITEMS_PER_BLOCK) send_random_text();
        end

        settle();
        @(negedge clk);
        $display("Run covered %0d text bytes and %0d terminators under %0d code settings,",
                 n_bytes, n_terms, n_settings);
        $display("incl. deep nesting, escapes, stray closers and overlapping codes; %0d results.",
                 results_seen);
        if (fail_count == 0) begin
            $display("[markup_bracket_balance_checker] OK");
        end else begin
            $display("[markup_bracket_balance_checker] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mbbc_pkg.sv
rtl/core/markup_bracket_balance_checker.sv
tb/bracket_result_checker.sv
tb/tb_markup_bracket_balance_checker.sv
